/* src/sbld_pkg.sv */
package sbld_pkg;

   // Default address width used for target wrap
   localparam int ADDR_BITS_DEFAULT = 16;

   // Configuration register indexes
   localparam logic CSR_FORMAT_VERSION = 1'b0;
   localparam logic CSR_SEQUENCE_END   = 1'b1;

   localparam logic [2:0]  FORMAT_VERSION_RESET = 3'd0;
   localparam logic [15:0] SEQUENCE_END_RESET   = 16'hFFFF;

   // Format versions
   localparam logic [2:0] VER_1_0 = 3'd0;
   localparam logic [2:0] VER_1_1 = 3'd1;
   localparam logic [2:0] VER_1_2 = 3'd2;
   localparam logic [2:0] VER_2_0 = 3'd3;
   localparam logic [2:0] VER_3_0 = 3'd4;
   localparam logic [2:0] VER_3_2 = 3'd6;

   // Target kinds
   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_JUMP   = 3'd1;
   localparam logic [2:0] KIND_BRANCH = 3'd2;
   localparam logic [2:0] KIND_CUSTOM = 3'd3;
   localparam logic [2:0] KIND_DRUM   = 3'd4;

   // Status opcodes
   localparam logic [7:0] OP_NOTE_LAST   = 8'h99;
   localparam logic [7:0] OP_END_FIRST   = 8'h9a;
   localparam logic [7:0] OP_END_LAST    = 8'ha0;
   localparam logic [7:0] OP_V3_LOW      = 8'hf0;
   localparam logic [7:0] OP_V3_HIGH     = 8'hfd;
   localparam logic [7:0] OP_PREFIX_V3   = 8'hfe;
   localparam logic [7:0] OP_PREFIX_V2   = 8'hfc;
   localparam logic [7:0] OP_ART_A1      = 8'ha1;
   localparam logic [7:0] OP_ART_F2      = 8'hf2;
   localparam logic [7:0] OP_ART_F4      = 8'hf4;
   localparam logic [7:0] OP_DRUM        = 8'hec;
   localparam logic [7:0] OP_JUMP        = 8'hee;
   localparam logic [7:0] OP_BRANCH_EF   = 8'hef;
   localparam logic [7:0] OP_BRANCH_F0   = 8'hf0;
   localparam logic [7:0] OP_BRANCH_F1   = 8'hf1;
   localparam logic [7:0] OP_CUSTOM      = 8'hfc;

   // Prefixed sub-opcodes
   localparam logic [7:0] SUB_DRUM       = 8'h04;
   localparam logic [7:0] SUB_JUMP       = 8'h06;
   localparam logic [7:0] SUB_BRANCH_07  = 8'h07;
   localparam logic [7:0] SUB_BRANCH_08  = 8'h08;
   localparam logic [7:0] SUB_BRANCH_09  = 8'h09;
   localparam logic [7:0] SUB_ART        = 8'h0a;
   localparam logic [7:0] SUB_BRANCH_0E  = 8'h0e;
   localparam logic [7:0] SUB_CUSTOM     = 8'h14;

   typedef struct packed {
      logic [2:0]  format_version;
      logic [15:0] sequence_end;
   } cfg_type;

   typedef struct packed {
      logic [15:0] cmd_offset;
      logic [7:0]  opcode_byte;
      logic [7:0]  byte_one;
      logic [7:0]  byte_two;
      logic [7:0]  byte_three;
      logic [7:0]  byte_four;
      logic [2:0]  bytes_present;
   } req_type;

   typedef struct packed {
      logic [2:0]  cmd_length;
      logic        is_terminal;
      logic [2:0]  target_kind;
      logic [15:0] target_address;
      logic        uses_articulation;
      logic        art_id_valid;
      logic [7:0]  art_id;
   } rsp_type;

endpackage

/* src/sbld_csr.sv */
module sbld_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data,
   output sbld_pkg::cfg_type    cfg
);

   logic [2:0]  format_version_ff, format_version_in;
   logic [15:0] sequence_end_ff, sequence_end_in;

   always_comb begin
      format_version_in = format_version_ff;
      sequence_end_in   = sequence_end_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sbld_pkg::CSR_FORMAT_VERSION: format_version_in = csr_data[2:0];
            sbld_pkg::CSR_SEQUENCE_END:   sequence_end_in   = csr_data;
            default:                      format_version_in = format_version_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_version_ff <= sbld_pkg::FORMAT_VERSION_RESET;
         sequence_end_ff   <= sbld_pkg::SEQUENCE_END_RESET;
      end else begin
         format_version_ff <= format_version_in;
         sequence_end_ff   <= sequence_end_in;
      end
   end

   assign cfg.format_version = format_version_ff;
   assign cfg.sequence_end   = sequence_end_ff;

endmodule

/* src/sbld_decode.sv */
module sbld_decode #(
   parameter int ADDR_BITS = sbld_pkg::ADDR_BITS_DEFAULT
) (
   input  sbld_pkg::cfg_type cfg,
   input  sbld_pkg::req_type req,
   output sbld_pkg::rsp_type rsp
);

   localparam logic [15:0] AddrMask =
      (ADDR_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << ADDR_BITS) - 64'd1);

   // operand bytes after the opcode, direct commands
   function automatic logic [2:0] direct_bytes(input logic [7:0] s, input logic [2:0] v);
      logic v01;
      v01 = (v <= sbld_pkg::VER_1_1);
      unique case (s)
         8'ha1, 8'ha2, 8'ha3, 8'ha5, 8'ha8, 8'haa, 8'hac, 8'had, 8'hae, 8'haf,
         8'hb1, 8'hb2, 8'hb5, 8'hb7, 8'hb9, 8'hbb, 8'hbd, 8'hbf, 8'hc0, 8'hc1,
         8'hc9, 8'hce, 8'hcf, 8'hd2, 8'hd3, 8'hd8, 8'hd9, 8'hda, 8'hdc:
            direct_bytes = 3'd1;
         8'ha4, 8'ha9, 8'hab, 8'hb0, 8'hbc, 8'hdd, 8'hde, 8'hdf:
            direct_bytes = 3'd2;
         8'hb4, 8'hb8:
            direct_bytes = 3'd3;
         8'he1:
            direct_bytes = (v == sbld_pkg::VER_3_2) ? 3'd1 : 3'd0;
         8'he4, 8'he5, 8'he6:
            direct_bytes = (v == sbld_pkg::VER_3_2) ? 3'd2 : 3'd0;
         8'he8, 8'hea, 8'hee, 8'hec, 8'hfd, 8'hfe:
            direct_bytes = v01 ? 3'd2 : 3'd0;
         8'he9, 8'heb, 8'hef, 8'hf0, 8'hf1:
            direct_bytes = v01 ? 3'd3 : 3'd0;
         8'hf2:
            direct_bytes = v01 ? 3'd1 : 3'd0;
         8'hf4, 8'hf6, 8'hf7:
            direct_bytes = (v == sbld_pkg::VER_1_0) ? 3'd2 : 3'd0;
         8'hf8:
            direct_bytes = (v == sbld_pkg::VER_1_0) ? 3'd1 : 3'd0;
         8'hfc:
            direct_bytes = (v == sbld_pkg::VER_1_1) ? 3'd2 : 3'd0;
         default:
            direct_bytes = 3'd0;
      endcase
   endfunction

   // operand bytes after the sub-opcode, prefixed commands
   function automatic logic [2:0] sub_bytes(input logic [7:0] s, input logic [2:0] v);
      logic v3;
      v3 = (v >= sbld_pkg::VER_3_0);
      unique case (s)
         8'h00, 8'h02, 8'h15, 8'h16, 8'h12, 8'h19,
         8'h06, 8'h0c, 8'h17, 8'h18:   sub_bytes = 3'd2;
         8'h14:                        sub_bytes = v3 ? 3'd1 : 3'd2;
         8'h01, 8'h03, 8'h07, 8'h08,
         8'h09:                        sub_bytes = 3'd3;
         8'h04:                        sub_bytes = v3 ? 3'd0 : 3'd2;
         8'h0e:                        sub_bytes = (v == sbld_pkg::VER_3_2) ? 3'd2 : 3'd1;
         8'h0a, 8'h10, 8'h1c:          sub_bytes = 3'd1;
         8'h0f:                        sub_bytes = (v == sbld_pkg::VER_3_2) ? 3'd0 : 3'd2;
         default:                      sub_bytes = 3'd0;
      endcase
   endfunction

   logic [2:0]  ver;
   logic        v3;
   logic        v01;
   logic [2:0]  present;
   logic [5:1]  have_end;      // bytes [0, e) all exist
   logic [15:0] base1, base2, base3;
   logic [15:0] dest1, dest2, dest2b, dest3;
   logic [7:0]  st;
   logic [7:0]  sub;
   logic        prefix;

   always_comb begin
      ver     = (cfg.format_version > sbld_pkg::VER_3_2) ? sbld_pkg::VER_3_2
                                                          : cfg.format_version;
      v3      = (ver >= sbld_pkg::VER_3_0);
      v01     = (ver <= sbld_pkg::VER_1_1);
      present = (req.bytes_present > 3'd5) ? 3'd5 : req.bytes_present;
      for (int e = 1; e <= 5; e++) begin
         have_end[e] = (3'(e) <= present) &&
                       ({1'b0, req.cmd_offset} + 17'(e) <= {1'b0, cfg.sequence_end});
      end
   end

   // relative destinations; pre-3 formats add two
   always_comb begin
      base1  = req.cmd_offset + (v3 ? 16'd1 : 16'd3);
      base2  = req.cmd_offset + (v3 ? 16'd2 : 16'd4);
      base3  = req.cmd_offset + (v3 ? 16'd3 : 16'd5);
      dest1  = (base1 + {req.byte_two, req.byte_one}) & AddrMask;
      dest2  = (base2 + {req.byte_three, req.byte_two}) & AddrMask;
      dest2b = dest2;
      dest3  = (base3 + {req.byte_four, req.byte_three}) & AddrMask;
   end

   always_comb begin
      st     = req.opcode_byte;
      sub    = req.byte_one;
      prefix = (v3 && st == sbld_pkg::OP_PREFIX_V3) ||
               ((ver == sbld_pkg::VER_1_2 || ver == sbld_pkg::VER_2_0) &&
                st == sbld_pkg::OP_PREFIX_V2);
      rsp = '0;
      priority if (!have_end[1]) begin
         rsp.is_terminal = 1'b1;
      end else if (st <= sbld_pkg::OP_NOTE_LAST ||
                   (v3 && st >= sbld_pkg::OP_V3_LOW && st <= sbld_pkg::OP_V3_HIGH)) begin
         rsp.cmd_length = (v3 && st >= sbld_pkg::OP_V3_LOW) ? 3'd2 : 3'd1;
      end else if (st >= sbld_pkg::OP_END_FIRST && st <= sbld_pkg::OP_END_LAST) begin
         rsp.is_terminal = 1'b1;
      end else if (prefix) begin
         if (!have_end[2]) begin
            rsp.is_terminal = 1'b1;
         end else begin
            rsp.cmd_length = 3'd2 + sub_bytes(sub, ver);
            priority if (sub == sbld_pkg::SUB_DRUM && !v3 && have_end[4]) begin
               rsp.target_kind    = sbld_pkg::KIND_DRUM;
               rsp.target_address = dest2;
            end else if (sub == sbld_pkg::SUB_JUMP && have_end[4]) begin
               rsp.target_kind    = sbld_pkg::KIND_JUMP;
               rsp.target_address = dest2;
            end else if ((sub == sbld_pkg::SUB_BRANCH_07 || sub == sbld_pkg::SUB_BRANCH_08 ||
                          sub == sbld_pkg::SUB_BRANCH_09) && have_end[5]) begin
               rsp.target_kind    = sbld_pkg::KIND_BRANCH;
               rsp.target_address = dest3;
            end else if (sub == sbld_pkg::SUB_ART) begin
               rsp.uses_articulation = 1'b1;
               if (have_end[3]) begin
                  rsp.art_id_valid = 1'b1;
                  rsp.art_id       = req.byte_two;
               end
            end else if (sub == sbld_pkg::SUB_BRANCH_0E && ver == sbld_pkg::VER_3_2 &&
                         have_end[4]) begin
               rsp.target_kind    = sbld_pkg::KIND_BRANCH;
               rsp.target_address = dest2b;
            end else if (sub == sbld_pkg::SUB_CUSTOM && !v3 && have_end[4]) begin
               rsp.target_kind    = sbld_pkg::KIND_CUSTOM;
               rsp.target_address = dest2;
            end else begin
               rsp.target_kind = sbld_pkg::KIND_NONE;
            end
         end
      end else begin
         rsp.cmd_length = 3'd1 + direct_bytes(st, ver);
         priority if (st == sbld_pkg::OP_ART_A1 || st == sbld_pkg::OP_ART_F2 ||
                      (st == sbld_pkg::OP_ART_F4 && ver == sbld_pkg::VER_1_0)) begin
            rsp.uses_articulation = 1'b1;
            if (have_end[2]) begin
               rsp.art_id_valid = 1'b1;
               rsp.art_id       = req.byte_one;
            end
         end else if (st == sbld_pkg::OP_DRUM && v01 && have_end[3]) begin
            rsp.target_kind    = sbld_pkg::KIND_DRUM;
            rsp.target_address = dest1;
         end else if (st == sbld_pkg::OP_JUMP && v01 && have_end[3]) begin
            rsp.target_kind    = sbld_pkg::KIND_JUMP;
            rsp.target_address = dest1;
         end else if ((st == sbld_pkg::OP_BRANCH_EF || st == sbld_pkg::OP_BRANCH_F0 ||
                       st == sbld_pkg::OP_BRANCH_F1) && v01 && have_end[4]) begin
            rsp.target_kind    = sbld_pkg::KIND_BRANCH;
            rsp.target_address = dest2;
         end else if (st == sbld_pkg::OP_CUSTOM && ver == sbld_pkg::VER_1_1 &&
                      have_end[3]) begin
            rsp.target_kind    = sbld_pkg::KIND_CUSTOM;
            rsp.target_address = dest1;
         end else begin
            rsp.target_kind = sbld_pkg::KIND_NONE;
         end
      end
   end

endmodule

/* src/sequence_bytecode_length_decoder.sv */
// Sequence bytecode command decoder.
// Request channel (req_*): one transaction carries a command address, the
// five bytes starting there and how many of them are present.
// Response channel (rsp_*): one transaction per request, in order, with the
// command length, terminal flag, optional target and articulation info.
// Config channel (csr_*): index 0 writes the format version, index 1 the
// sequence end address. csr_ready is always high; write only while idle.
// Path: request register, then decode into the response register.
// Throughput: one transaction per cycle while rsp_ready is high; the
// decode is a table lookup plus 16-bit adds for the relative target.
// Reset: format version 1.0, sequence end 0xFFFF, both stages empty.
// Stall: when rsp_ready is low the response register holds; the request
// register still fills, so req_ready drops only when both stages are full.
module sequence_bytecode_length_decoder #(
   parameter int ADDR_BITS = sbld_pkg::ADDR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_cmd_offset,
   input  logic [7:0]  req_opcode_byte,
   input  logic [7:0]  req_byte_one,
   input  logic [7:0]  req_byte_two,
   input  logic [7:0]  req_byte_three,
   input  logic [7:0]  req_byte_four,
   input  logic [2:0]  req_bytes_present,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_cmd_length,
   output logic        rsp_is_terminal,
   output logic [2:0]  rsp_target_kind,
   output logic [15:0] rsp_target_address,
   output logic        rsp_uses_articulation,
   output logic        rsp_art_id_valid,
   output logic [7:0]  rsp_art_id,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   sbld_pkg::cfg_type cfg;
   sbld_pkg::req_type req_ff, req_in;
   sbld_pkg::rsp_type rsp_ff, rsp_in;
   sbld_pkg::rsp_type dec_rsp;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_take;       // response register can load
   logic              in_take;        // request register can load

   assign csr_ready = 1'b1;

   sbld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbld_decode #(
      .ADDR_BITS (ADDR_BITS)
   ) u_decode (
      .cfg (cfg),
      .req (req_ff),
      .rsp (dec_rsp)
   );

   // two-stage pipe with back-pressure through both stages
   assign out_take  = !out_valid_ff || rsp_ready;
   assign in_take   = !in_valid_ff || out_take;
   assign req_ready = in_take;

   always_comb begin
      in_valid_in  = in_take ? req_valid : in_valid_ff;
      out_valid_in = out_take ? in_valid_ff : out_valid_ff;
      req_in       = req_ff;
      if (req_valid && in_take) begin
         req_in.cmd_offset    = req_cmd_offset;
         req_in.opcode_byte   = req_opcode_byte;
         req_in.byte_one      = req_byte_one;
         req_in.byte_two      = req_byte_two;
         req_in.byte_three    = req_byte_three;
         req_in.byte_four     = req_byte_four;
         req_in.bytes_present = req_bytes_present;
      end
      rsp_in = (in_valid_ff && out_take) ? dec_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_cmd_length        = rsp_ff.cmd_length;
   assign rsp_is_terminal       = rsp_ff.is_terminal;
   assign rsp_target_kind       = rsp_ff.target_kind;
   assign rsp_target_address    = rsp_ff.target_address;
   assign rsp_uses_articulation = rsp_ff.uses_articulation;
   assign rsp_art_id_valid      = rsp_ff.art_id_valid;
   assign rsp_art_id            = rsp_ff.art_id;

`ifndef SYNTHESIS
   // terminal commands report zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminal |-> rsp_cmd_length == 3'd0)
      else $error("terminal response with nonzero length");

   // no target means a zero address field
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_kind == sbld_pkg::KIND_NONE |-> rsp_target_address == 16'd0)
      else $error("address set without target kind");

   // an articulation id only comes with an articulation command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_art_id_valid |-> rsp_uses_articulation &&
                                          rsp_target_kind == sbld_pkg::KIND_NONE)
      else $error("articulation id without articulation use");

   // empty response register never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response stage");
`endif

endmodule

/* tb/sequence_bytecode_length_decoder_tb.sv */
`timescale 1ns / 1ps

module sequence_bytecode_length_decoder_tb;
   import sbld_pkg::*;

   // Version 3.1 has no name in the package; 7 is the out-of-range code
   // that the block must treat as 3.2.
   localparam logic [2:0] VER_3_1       = 3'd5;
   localparam logic [2:0] VER_RAW_MAX   = 3'd7;
   localparam int         DECODE_LATENCY = 2;
   localparam int         STALL_LIMIT    = 2000;
   localparam int         LONG_HOLD      = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_cmd_offset = '0;
   logic [7:0]  req_opcode_byte = '0;
   logic [7:0]  req_byte_one = '0;
   logic [7:0]  req_byte_two = '0;
   logic [7:0]  req_byte_three = '0;
   logic [7:0]  req_byte_four = '0;
   logic [2:0]  req_bytes_present = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_cmd_length;
   logic        rsp_is_terminal;
   logic [2:0]  rsp_target_kind;
   logic [15:0] rsp_target_address;
   logic        rsp_uses_articulation;
   logic        rsp_art_id_valid;
   logic [7:0]  rsp_art_id;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_FORMAT_VERSION;
   logic [15:0] csr_data = '0;

   // Shadow of the block's registers, updated when a CSR write is accepted
   logic [2:0]  cfg_version = FORMAT_VERSION_RESET;
   logic [15:0] cfg_seq_end = SEQUENCE_END_RESET;

   // Decoded commands still owed by the block, oldest first
   rsp_type     pending_decodes[$];
   rsp_type     want;

   bit          idle_on = 1'b1;      // random bursts of idling on both sides
   int          sink_hold_cycles = 0; // one-shot long stall request for the sink
   int          fail_count = 0;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   sequence_bytecode_length_decoder dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd_offset        (req_cmd_offset),
      .req_opcode_byte       (req_opcode_byte),
      .req_byte_one          (req_byte_one),
      .req_byte_two          (req_byte_two),
      .req_byte_three        (req_byte_three),
      .req_byte_four         (req_byte_four),
      .req_bytes_present     (req_bytes_present),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_cmd_length        (rsp_cmd_length),
      .rsp_is_terminal       (rsp_is_terminal),
      .rsp_target_kind       (rsp_target_kind),
      .rsp_target_address    (rsp_target_address),
      .rsp_uses_articulation (rsp_uses_articulation),
      .rsp_art_id_valid      (rsp_art_id_valid),
      .rsp_art_id            (rsp_art_id),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // ---------------------------------------------------------------
   // Command decode prediction
   // ---------------------------------------------------------------

   // Operand bytes that follow a plain (unprefixed) opcode
   function automatic int direct_operand_bytes(input logic [7:0] op, input logic [2:0] ver);
      logic early;
      early = (ver <= VER_1_1);
      case (op)
         8'ha1, 8'ha2, 8'ha3, 8'ha5, 8'ha8, 8'haa, 8'hac, 8'had, 8'hae, 8'haf,
         8'hb1, 8'hb2, 8'hb5, 8'hb7, 8'hb9, 8'hbb, 8'hbd, 8'hbf, 8'hc0, 8'hc1,
         8'hc9, 8'hce, 8'hcf, 8'hd2, 8'hd3, 8'hd8, 8'hd9, 8'hda, 8'hdc:
            return 1;
         8'ha4, 8'ha9, 8'hab, 8'hb0, 8'hbc, 8'hdd, 8'hde, 8'hdf:
            return 2;
         8'hb4, 8'hb8:
            return 3;
         8'he1:                         return (ver == VER_3_2) ? 1 : 0;
         8'he4, 8'he5, 8'he6:           return (ver == VER_3_2) ? 2 : 0;
         8'he8, 8'hea, 8'hee, 8'hec, 8'hfd, 8'hfe:
            return early ? 2 : 0;
         8'he9, 8'heb, 8'hef, 8'hf0, 8'hf1:
            return early ? 3 : 0;
         8'hf2:                         return early ? 1 : 0;
         8'hf4, 8'hf6, 8'hf7:           return (ver == VER_1_0) ? 2 : 0;
         8'hf8:                         return (ver == VER_1_0) ? 1 : 0;
         8'hfc:                         return (ver == VER_1_1) ? 2 : 0;
         default:                       return 0;
      endcase
   endfunction

   // Operand bytes that follow a sub-opcode after the prefix
   function automatic int prefixed_operand_bytes(input logic [7:0] sub, input logic [2:0] ver);
      logic third_gen;
      third_gen = (ver >= VER_3_0);
      case (sub)
         8'h00, 8'h02, 8'h15, 8'h16, 8'h12, 8'h19,
         8'h06, 8'h0c, 8'h17, 8'h18:    return 2;
         8'h14:                         return third_gen ? 1 : 2;
         8'h01, 8'h03, 8'h07, 8'h08, 8'h09:
            return 3;
         8'h04:                         return third_gen ? 0 : 2;
         8'h0e:                         return (ver == VER_3_2) ? 2 : 1;
         8'h0a, 8'h10, 8'h1c:           return 1;
         8'h0f:                         return (ver == VER_3_2) ? 0 : 2;
         default:                       return 0;
      endcase
   endfunction

   // n bytes starting at byte k exist in the buffer and before the sequence end
   function automatic bit bytes_exist(input req_type c, input int k, input int n);
      int avail;
      avail = (c.bytes_present > 5) ? 5 : int'(c.bytes_present);
      return (k + n <= avail) && (int'(c.cmd_offset) + k + n <= int'(cfg_seq_end));
   endfunction

   // Operand address plus signed 16-bit displacement, plus two before format 3; wraps at 16 bits
   function automatic logic [15:0] rel_target(input logic [15:0] base, input int k,
                                              input logic [7:0] lo, input logic [7:0] hi,
                                              input bit third_gen);
      logic [15:0] step;
      logic [15:0] bias;
      step = 16'(k);
      bias = third_gen ? 16'd0 : 16'd2;
      return base + step + {hi, lo} + bias;
   endfunction

   function automatic rsp_type decode_command(input req_type c);
      rsp_type     r;
      logic [2:0]  ver;
      logic [7:0]  op;
      logic [7:0]  sub;
      bit          third_gen;
      bit          early;
      bit          prefixed;
      r         = '0;
      ver       = (cfg_version > VER_3_2) ? VER_3_2 : cfg_version;  // saturate
      third_gen = (ver >= VER_3_0);
      early     = (ver <= VER_1_1);
      op        = c.opcode_byte;
      sub       = c.byte_one;
      prefixed  = (third_gen && op == OP_PREFIX_V3) ||
                  ((ver == VER_1_2 || ver == VER_2_0) && op == OP_PREFIX_V2);

      if (!bytes_exist(c, 0, 1)) begin
         r.is_terminal = 1'b1;
      end else if (op <= OP_NOTE_LAST || (third_gen && op >= OP_V3_LOW && op <= OP_V3_HIGH)) begin
         r.cmd_length = (third_gen && op >= OP_V3_LOW) ? 3'd2 : 3'd1;
      end else if (op >= OP_END_FIRST && op <= OP_END_LAST) begin
         r.is_terminal = 1'b1;
      end else if (prefixed) begin
         if (!bytes_exist(c, 0, 2)) begin
            // sub-opcode missing
            r.is_terminal = 1'b1;
         end else begin
            r.cmd_length = 3'(2 + prefixed_operand_bytes(sub, ver));
            if (sub == SUB_DRUM && !third_gen && bytes_exist(c, 2, 2)) begin
               r.target_kind    = KIND_DRUM;
               r.target_address = rel_target(c.cmd_offset, 2, c.byte_two, c.byte_three,
                                             third_gen);
            end else if (sub == SUB_JUMP && bytes_exist(c, 2, 2)) begin
               r.target_kind    = KIND_JUMP;
               r.target_address = rel_target(c.cmd_offset, 2, c.byte_two, c.byte_three,
                                             third_gen);
            end else if ((sub == SUB_BRANCH_07 || sub == SUB_BRANCH_08 ||
                          sub == SUB_BRANCH_09) && bytes_exist(c, 3, 2)) begin
               r.target_kind    = KIND_BRANCH;
               r.target_address = rel_target(c.cmd_offset, 3, c.byte_three, c.byte_four,
                                             third_gen);
            end else if (sub == SUB_ART) begin
               r.uses_articulation = 1'b1;
               if (bytes_exist(c, 2, 1)) begin
                  r.art_id_valid = 1'b1;
                  r.art_id       = c.byte_two;
               end
            end else if (sub == SUB_BRANCH_0E && ver == VER_3_2 && bytes_exist(c, 2, 2)) begin
               r.target_kind    = KIND_BRANCH;
               r.target_address = rel_target(c.cmd_offset, 2, c.byte_two, c.byte_three,
                                             third_gen);
            end else if (sub == SUB_CUSTOM && !third_gen && bytes_exist(c, 2, 2)) begin
               r.target_kind    = KIND_CUSTOM;
               r.target_address = rel_target(c.cmd_offset, 2, c.byte_two, c.byte_three,
                                             third_gen);
            end
         end
      end else begin
         r.cmd_length = 3'(1 + direct_operand_bytes(op, ver));
         if (op == OP_ART_A1 || op == OP_ART_F2 || (op == OP_ART_F4 && ver == VER_1_0)) begin
            r.uses_articulation = 1'b1;
            if (bytes_exist(c, 1, 1)) begin
               r.art_id_valid = 1'b1;
               r.art_id       = c.byte_one;
            end
         end else if (op == OP_DRUM && early && bytes_exist(c, 1, 2)) begin
            r.target_kind    = KIND_DRUM;
            r.target_address = rel_target(c.cmd_offset, 1, c.byte_one, c.byte_two, third_gen);
         end else if (op == OP_JUMP && early && bytes_exist(c, 1, 2)) begin
            r.target_kind    = KIND_JUMP;
            r.target_address = rel_target(c.cmd_offset, 1, c.byte_one, c.byte_two, third_gen);
         end else if ((op == OP_BRANCH_EF || op == OP_BRANCH_F0 || op == OP_BRANCH_F1) &&
                      early && bytes_exist(c, 2, 2)) begin
            r.target_kind    = KIND_BRANCH;
            r.target_address = rel_target(c.cmd_offset, 2, c.byte_two, c.byte_three,
                                          third_gen);
         end else if (op == OP_CUSTOM && ver == VER_1_1 && bytes_exist(c, 1, 2)) begin
            r.target_kind    = KIND_CUSTOM;
            r.target_address = rel_target(c.cmd_offset, 1, c.byte_one, c.byte_two, third_gen);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Command builders
   // ---------------------------------------------------------------

   function automatic req_type make_cmd(input logic [15:0] off, input logic [7:0] op,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3, input logic [7:0] b4,
                                        input logic [2:0] present);
      req_type c;
      c.cmd_offset    = off;
      c.opcode_byte   = op;
      c.byte_one      = b1;
      c.byte_two      = b2;
      c.byte_three    = b3;
      c.byte_four     = b4;
      c.bytes_present = present;
      return c;
   endfunction

   // Mostly complete commands placed inside the sequence, with opcodes biased
   // toward the ones that carry targets, articulation ids or prefixes.
   function automatic req_type random_command();
      req_type c;
      int      pick;
      int      where;
      c.byte_one   = 8'($urandom);
      c.byte_two   = 8'($urandom);
      c.byte_three = 8'($urandom);
      c.byte_four  = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         c.opcode_byte = 8'($urandom);
      end else if (pick < 60) begin
         case ($urandom_range(0, 11))
            0:       c.opcode_byte = OP_ART_A1;
            1:       c.opcode_byte = OP_ART_F2;
            2:       c.opcode_byte = OP_ART_F4;
            3:       c.opcode_byte = OP_DRUM;
            4:       c.opcode_byte = OP_JUMP;
            5:       c.opcode_byte = OP_BRANCH_EF;
            6:       c.opcode_byte = OP_BRANCH_F0;
            7:       c.opcode_byte = OP_BRANCH_F1;
            8:       c.opcode_byte = OP_CUSTOM;
            9:       c.opcode_byte = OP_V3_HIGH;
            10:      c.opcode_byte = OP_NOTE_LAST;
            default: c.opcode_byte = 8'($urandom_range(OP_ART_A1, 8'hff));
         endcase
      end else if (pick < 90) begin
         // prefix of the current generation, now and then the other one
         c.opcode_byte = (cfg_version >= VER_3_0) ? OP_PREFIX_V3 : OP_PREFIX_V2;
         if ($urandom_range(0, 7) == 0)
            c.opcode_byte = (c.opcode_byte == OP_PREFIX_V3) ? OP_PREFIX_V2 : OP_PREFIX_V3;
         case ($urandom_range(0, 15))
            0:       c.byte_one = SUB_DRUM;
            1:       c.byte_one = SUB_JUMP;
            2:       c.byte_one = SUB_BRANCH_07;
            3:       c.byte_one = SUB_BRANCH_08;
            4:       c.byte_one = SUB_BRANCH_09;
            5:       c.byte_one = SUB_ART;
            6:       c.byte_one = SUB_BRANCH_0E;
            7:       c.byte_one = SUB_CUSTOM;
            8:       c.byte_one = 8'($urandom);
            default: c.byte_one = 8'($urandom_range(0, 8'h1f));
         endcase
      end else begin
         c.opcode_byte = 8'($urandom_range(OP_END_FIRST, OP_END_LAST));
      end

      c.bytes_present = ($urandom_range(0, 3) != 0) ? 3'd5 : 3'($urandom_range(0, 7));

      where = $urandom_range(0, 99);
      if (where < 70 && cfg_seq_end >= 5)
         c.cmd_offset = 16'($urandom_range(0, int'(cfg_seq_end) - 5));
      else if (where < 85)
         c.cmd_offset = cfg_seq_end - 16'($urandom_range(0, 6));  // straddles the end
      else
         c.cmd_offset = 16'($urandom);
      return c;
   endfunction

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------

   // Offers one command and returns at the edge where it is accepted. Valid
   // stays high afterwards so back-to-back commands go out without a bubble.
   task automatic issue_command(input req_type c);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd_offset    <= c.cmd_offset;
      req_opcode_byte   <= c.opcode_byte;
      req_byte_one      <= c.byte_one;
      req_byte_two      <= c.byte_two;
      req_byte_three    <= c.byte_three;
      req_byte_four     <= c.byte_four;
      req_bytes_present <= c.bytes_present;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_decodes.insert(pending_decodes.size(), decode_command(c));
   endtask

   // Stop offering and wait for every owed response. Always waits for a
   // clock edge first so the next drive of req_valid lands in a later step.
   task automatic drain_decodes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   // Both registers in one CSR burst; valid stays up between the two writes
   task automatic load_format(input logic [2:0] ver, input logic [15:0] seq_end);
      logic [15:0] ver_word;
      ver_word = {13'($urandom), ver};   // upper bits are don't-care
      drain_decodes();
      repeat (DECODE_LATENCY + 2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_FORMAT_VERSION;
      csr_data  <= ver_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_version = ver;
      csr_index <= CSR_SEQUENCE_END;
      csr_data  <= seq_end;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_seq_end = seq_end;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Response sink: random stalls, plus one long hold on request
   // ---------------------------------------------------------------

   initial begin : rsp_sink
      int n;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (sink_hold_cycles > 0) begin
            n = sink_hold_cycles;
            sink_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response check against the oldest owed decode
   // ---------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_decodes.size() == 0) begin
            $error("response transaction with no command outstanding");
            fail_count++;
         end else begin
            want = pending_decodes.pop_front();
            check_field("cmd_length", 16'(want.cmd_length), 16'(rsp_cmd_length));
            check_field("is_terminal", 16'(want.is_terminal), 16'(rsp_is_terminal));
            check_field("target_kind", 16'(want.target_kind), 16'(rsp_target_kind));
            check_field("target_address", want.target_address, rsp_target_address);
            check_field("uses_articulation", 16'(want.uses_articulation),
                        16'(rsp_uses_articulation));
            check_field("art_id_valid", 16'(want.art_id_valid), 16'(rsp_art_id_valid));
            check_field("art_id", 16'(want.art_id), 16'(rsp_art_id));
         end
      end
   end

   // Watchdog: no transaction on any channel for too long means a hang
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Runs on the reset register values (1.0, end 0xFFFF): field extremes,
   // empty buffer, end-of-track range, oversized byte counts.
   task automatic test_reset_limits();
      issue_command(make_cmd(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5));
      // last address: opcode byte lies at the sequence end -> terminal
      issue_command(make_cmd(16'hffff, OP_NOTE_LAST, 8'hff, 8'hff, 8'hff, 8'hff, 3'd5));
      issue_command(make_cmd(16'h1234, 8'h10, 8'h11, 8'h22, 8'h33, 8'h44, 3'd0));
      issue_command(make_cmd(16'h0100, OP_END_FIRST, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5));
      issue_command(make_cmd(16'h0100, OP_END_LAST, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
      issue_command(make_cmd(16'hfffa, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 3'd6));
      drain_decodes();
   endtask

   // Articulation and target opcodes of the early formats, with short buffers
   task automatic test_direct_opcodes();
      issue_command(make_cmd(16'h0200, OP_ART_A1, 8'hff, 8'h00, 8'h00, 8'h00, 3'd2));
      issue_command(make_cmd(16'h0200, OP_ART_A1, 8'h12, 8'h00, 8'h00, 8'h00, 3'd1));
      issue_command(make_cmd(16'h0300, OP_ART_F4, 8'h5a, 8'ha5, 8'h00, 8'h00, 3'd5));
      // backward drum target that wraps below zero
      issue_command(make_cmd(16'h0001, OP_DRUM, 8'hf0, 8'hff, 8'h00, 8'h00, 3'd5));
      // forward jump that wraps past the top
      issue_command(make_cmd(16'hfff0, OP_JUMP, 8'h20, 8'h00, 8'h00, 8'h00, 3'd5));
      // jump operand cut short by the buffer
      issue_command(make_cmd(16'h0400, OP_JUMP, 8'h20, 8'h00, 8'h00, 8'h00, 3'd2));
      issue_command(make_cmd(16'h0500, OP_BRANCH_EF, 8'h01, 8'h80, 8'h7f, 8'h00, 3'd4));
      issue_command(make_cmd(16'h0600, 8'hf8, 8'h01, 8'h00, 8'h00, 8'h00, 3'd5));
      load_format(VER_1_1, SEQUENCE_END_RESET);
      issue_command(make_cmd(16'h0700, OP_CUSTOM, 8'h00, 8'h80, 8'h00, 8'h00, 3'd5));
      issue_command(make_cmd(16'h0800, OP_ART_F2, 8'h3c, 8'h00, 8'h00, 8'h00, 3'd5));
      drain_decodes();
   endtask

   // Prefixed commands of format 2.0
   task automatic test_prefixed_commands();
      load_format(VER_2_0, SEQUENCE_END_RESET);
      // sub-opcode byte missing -> terminal
      issue_command(make_cmd(16'h0900, OP_PREFIX_V2, SUB_JUMP, 8'h00, 8'h00, 8'h00, 3'd1));
      issue_command(make_cmd(16'h0900, OP_PREFIX_V2, SUB_DRUM, 8'h10, 8'h00, 8'h00, 3'd5));
      issue_command(make_cmd(16'h0a00, OP_PREFIX_V2, SUB_CUSTOM, 8'h00, 8'hf0, 8'h00, 3'd4));
      issue_command(make_cmd(16'h0b00, OP_PREFIX_V2, SUB_BRANCH_08, 8'h00, 8'hfe, 8'hff,
                             3'd5));
      // articulation sub-opcode with its id byte missing
      issue_command(make_cmd(16'h0c00, OP_PREFIX_V2, SUB_ART, 8'h77, 8'h00, 8'h00, 3'd2));
      drain_decodes();
   endtask

   // Register value seven behaves as 3.2
   task automatic test_version_saturation();
      load_format(VER_RAW_MAX, SEQUENCE_END_RESET);
      issue_command(make_cmd(16'h0d00, OP_PREFIX_V3, SUB_BRANCH_0E, 8'h40, 8'h00, 8'h00,
                             3'd5));
      issue_command(make_cmd(16'h0e00, OP_V3_HIGH, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5));
      drain_decodes();
   endtask

   // Sequence end truncates operands and, at the extreme, every command
   task automatic test_sequence_end();
      load_format(VER_1_1, 16'h0010);
      issue_command(make_cmd(16'h000e, OP_JUMP, 8'h04, 8'h00, 8'h00, 8'h00, 3'd5));
      issue_command(make_cmd(16'h0010, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5));
      load_format(VER_1_0, 16'h0000);
      issue_command(make_cmd(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5));
      drain_decodes();
   endtask

   // Every version code, each with its own sequence end, idling switched
   // on and off in stretches.
   task automatic test_version_sweep();
      logic [15:0] seq_end;
      for (int v = 0; v <= 7; v++) begin
         case (v % 3)
            0:       seq_end = SEQUENCE_END_RESET;
            1:       seq_end = 16'($urandom_range(16'h0040, 16'hfffe));
            default: seq_end = 16'($urandom_range(6, 16'h0200));
         endcase
         load_format(3'(v), seq_end);
         for (int i = 0; i < 160; i++) begin
            if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            issue_command(random_command());
         end
      end
      idle_on = 1'b1;
      drain_decodes();
   endtask

   // Sink holds off long enough for both stages to fill and req_ready to drop
   task automatic test_output_backpressure();
      load_format(VER_3_0, SEQUENCE_END_RESET);
      idle_on = 1'b0;
      sink_hold_cycles = LONG_HOLD;
      for (int i = 0; i < 24; i++) issue_command(random_command());
      drain_decodes();
      idle_on = 1'b1;
   endtask

   // Short bursts, each followed by a full drain before the next one
   task automatic test_burst_drain();
      load_format(VER_1_2, 16'($urandom_range(16'h0100, 16'hfff0)));
      for (int b = 0; b < 4; b++) begin
         for (int i = 0; i < 8; i++) issue_command(random_command());
         drain_decodes();
      end
   endtask

   // Closing stretch at full rate, no idling on either side
   task automatic test_full_rate();
      load_format(VER_3_1, SEQUENCE_END_RESET);
      idle_on = 1'b0;
      for (int i = 0; i < 200; i++) issue_command(random_command());
      drain_decodes();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_limits();
      test_direct_opcodes();
      test_prefixed_commands();
      test_version_saturation();
      test_sequence_end();
      test_version_sweep();
      test_output_backpressure();
      test_burst_drain();
      test_full_rate();

      drain_decodes();
      repeat (DECODE_LATENCY + 6) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
